// ===== src/fir_cb_pkg.sv =====
// ----------------------------------------------------------------------------
// fir_cb_pkg
// Shared types, constants and arithmetic helpers for the circular-buffer FIR.
// ----------------------------------------------------------------------------
package fir_cb_pkg;

   // Default configuration
   localparam int TAP_COUNT_DEF   = 81;
   localparam int SAMPLE_BITS_DEF = 16;
   localparam int COEF_BITS_DEF   = 16;

   // Fixed field and datapath widths
   localparam int INDEX_BITS = 7;
   localparam int ACC_BITS   = 64;

   // Request operation codes
   localparam logic OP_FILTER    = 1'b0;
   localparam logic OP_COEF_LOAD = 1'b1;

   // Control handed to every cell of the tap chain
   typedef struct packed {
      logic                  shift;       // push a new sample into the chain
      logic                  rotate;      // move both rings one cell toward cell 0
      logic                  coef_write;  // load one coefficient
      logic [INDEX_BITS-1:0] coef_index;
   } cell_ctrl_type;

   // Control handed to the multiply-accumulate unit
   typedef struct packed {
      logic clear;    // zero the accumulator
      logic capture;  // register the product of the head cell
      logic round;    // add the rounding constant
   } mac_ctrl_type;

   // Add two signed accumulator words, clamping at the signed bounds
   function automatic logic signed [ACC_BITS-1:0] sat_add(
      input logic signed [ACC_BITS-1:0] a,
      input logic signed [ACC_BITS-1:0] b
   );
      logic signed [ACC_BITS-1:0] sum;
      logic signed [ACC_BITS-1:0] result;
      sum = a + b;
      if ((a[ACC_BITS-1] == b[ACC_BITS-1]) && (sum[ACC_BITS-1] != a[ACC_BITS-1])) begin
         result = a[ACC_BITS-1] ? {1'b1, {(ACC_BITS-1){1'b0}}}
                                : {1'b0, {(ACC_BITS-1){1'b1}}};
      end else begin
         result = sum;
      end
      return result;
   endfunction

endpackage

// ===== src/fir_cb_cell.sv =====
// ----------------------------------------------------------------------------
// fir_cb_cell
// One tap of the chain: holds one sample and one coefficient, shifts samples
// forward on a new input and rotates both values toward the head cell.
// ----------------------------------------------------------------------------
module fir_cb_cell #(
   parameter int CELL_INDEX  = 0,
   parameter int SAMPLE_BITS = fir_cb_pkg::SAMPLE_BITS_DEF,
   parameter int COEF_BITS   = fir_cb_pkg::COEF_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  fir_cb_pkg::cell_ctrl_type     ctrl,
   input  logic signed [SAMPLE_BITS-1:0] sample_prev,
   input  logic signed [SAMPLE_BITS-1:0] sample_next,
   input  logic signed [COEF_BITS-1:0]   coef_next,
   input  logic signed [COEF_BITS-1:0]   coef_load,
   output logic signed [SAMPLE_BITS-1:0] sample,
   output logic signed [COEF_BITS-1:0]   coef
);
   import fir_cb_pkg::*;

   logic signed [SAMPLE_BITS-1:0] sample_ff, sample_in;
   logic signed [COEF_BITS-1:0]   coef_ff, coef_in;
   logic                          index_hit;

   assign index_hit = (32'(ctrl.coef_index) == CELL_INDEX);

   // Select the next sample and coefficient
   always_comb begin
      sample_in = sample_ff;
      coef_in   = coef_ff;
      if (ctrl.shift) begin
         sample_in = sample_prev;
      end else if (ctrl.rotate) begin
         sample_in = sample_next;
         coef_in   = coef_next;
      end else if (ctrl.coef_write && index_hit) begin
         coef_in   = coef_load;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_ff <= '0;
         coef_ff   <= '0;
      end else begin
         sample_ff <= sample_in;
         coef_ff   <= coef_in;
      end
   end

   assign sample = sample_ff;
   assign coef   = coef_ff;

endmodule

// ===== src/fir_cb_mac.sv =====
// ----------------------------------------------------------------------------
// fir_cb_mac
// Multiply-accumulate unit: registers one product per cycle, sums it into a
// saturating accumulator, rounds and clamps the total to the output format.
// ----------------------------------------------------------------------------
module fir_cb_mac #(
   parameter int SAMPLE_BITS = fir_cb_pkg::SAMPLE_BITS_DEF,
   parameter int COEF_BITS   = fir_cb_pkg::COEF_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  fir_cb_pkg::mac_ctrl_type      ctrl,
   input  logic signed [SAMPLE_BITS-1:0] sample,
   input  logic signed [COEF_BITS-1:0]   coef,
   output logic signed [SAMPLE_BITS-1:0] result,
   output logic                          clip
);
   import fir_cb_pkg::*;

   localparam int PROD_BITS = SAMPLE_BITS + COEF_BITS;
   localparam logic signed [ACC_BITS-1:0] ROUND_ADD = ACC_BITS'(1) <<< (COEF_BITS - 2);
   localparam logic signed [ACC_BITS-1:0] OUT_MAX   =
      (ACC_BITS'(1) <<< (SAMPLE_BITS - 1)) - ACC_BITS'(1);
   localparam logic signed [ACC_BITS-1:0] OUT_MIN   = -OUT_MAX - ACC_BITS'(1);

   logic signed [PROD_BITS-1:0] product_ff, product_in;
   logic                        prod_valid_ff, prod_valid_in;
   logic signed [ACC_BITS-1:0]  acc_ff, acc_in;
   logic signed [ACC_BITS-1:0]  scaled;

   // Form the product of the head cell
   assign product_in    = sample * coef;
   assign prod_valid_in = ctrl.capture;

   // Clear, round or accumulate
   always_comb begin
      acc_in = acc_ff;
      if (ctrl.clear) begin
         acc_in = '0;
      end else if (ctrl.round) begin
         acc_in = sat_add(acc_ff, ROUND_ADD);
      end else if (prod_valid_ff) begin
         acc_in = sat_add(acc_ff, ACC_BITS'(product_ff));
      end
   end

   always_ff @(posedge clock) begin
      product_ff <= product_in;
      if (reset) begin
         prod_valid_ff <= 1'b0;
         acc_ff        <= '0;
      end else begin
         prod_valid_ff <= prod_valid_in;
         acc_ff        <= acc_in;
      end
   end

   // Scale down and clamp to the sample range
   assign scaled = acc_ff >>> (COEF_BITS - 1);

   always_comb begin
      if (scaled > OUT_MAX) begin
         result = OUT_MAX[SAMPLE_BITS-1:0];
         clip   = 1'b1;
      end else if (scaled < OUT_MIN) begin
         result = OUT_MIN[SAMPLE_BITS-1:0];
         clip   = 1'b1;
      end else begin
         result = scaled[SAMPLE_BITS-1:0];
         clip   = 1'b0;
      end
   end

endmodule

// ===== src/fir_filter_circular_buffer_top.sv =====
// ----------------------------------------------------------------------------
// fir_filter_circular_buffer_top
// Direct-form FIR filter: a chain of tap cells holding samples and
// coefficients, rotated past one shared multiply-accumulate unit.
//
//   channel  direction  transaction
//   req_     in         filter one sample, or load one coefficient
//   rsp_     out        filtered sample and clip flag, one per filter request
//
// For a filter request the chain rotates once per tap through the single
// multiplier, the drain state adds the last product from the product
// register, the round state adds the rounding constant and the done state
// loads the output register. The block takes the next request only back in
// idle, once the output register is loaded. A coefficient load writes one
// cell and the block stays idle. Reset clears all samples, coefficients and
// control. A stalled result holds in the output register; the next request
// is taken while it waits, and the block stalls before its own result only
// if it still waits.
// ----------------------------------------------------------------------------
module fir_filter_circular_buffer_top #(
   parameter int TAP_COUNT   = fir_cb_pkg::TAP_COUNT_DEF,
   parameter int SAMPLE_BITS = fir_cb_pkg::SAMPLE_BITS_DEF,
   parameter int COEF_BITS   = fir_cb_pkg::COEF_BITS_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic                                    req_operation,
   input  logic signed [SAMPLE_BITS-1:0]           req_sample_in,
   input  logic [fir_cb_pkg::INDEX_BITS-1:0]       req_coef_index,
   input  logic signed [COEF_BITS-1:0]             req_coef_value,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic signed [SAMPLE_BITS-1:0]           rsp_filtered_out,
   output logic                                    rsp_clipped
);
   import fir_cb_pkg::*;

   localparam int CNT_BITS = (TAP_COUNT > 1) ? $clog2(TAP_COUNT) : 1;
   localparam logic [CNT_BITS-1:0] LAST_TAP = CNT_BITS'(TAP_COUNT - 1);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_RUN   = 5'b00010,
      ST_DRAIN = 5'b00100,
      ST_ROUND = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

   state_type                     state_ff, state_in;
   logic [CNT_BITS-1:0]           count_ff, count_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] rsp_data_ff, rsp_data_in;
   logic                          rsp_clip_ff, rsp_clip_in;

   logic                          accept;
   logic                          out_free;
   cell_ctrl_type                 cell_ctrl;
   mac_ctrl_type                  mac_ctrl;
   logic signed [SAMPLE_BITS-1:0] sample_w [TAP_COUNT];
   logic signed [COEF_BITS-1:0]   coef_w   [TAP_COUNT];
   logic signed [SAMPLE_BITS-1:0] mac_result;
   logic                          mac_clip;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // Drive the tap chain
   always_comb begin
      cell_ctrl.shift      = accept && (req_operation == OP_FILTER);
      cell_ctrl.rotate     = (state_ff == ST_RUN);
      cell_ctrl.coef_write = accept && (req_operation == OP_COEF_LOAD);
      cell_ctrl.coef_index = req_coef_index;
   end

   // Drive the multiply-accumulate unit
   always_comb begin
      mac_ctrl.clear   = accept && (req_operation == OP_FILTER);
      mac_ctrl.capture = (state_ff == ST_RUN);
      mac_ctrl.round   = (state_ff == ST_ROUND);
   end

   // Sequence one filter transaction
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      case (state_ff)
         ST_IDLE: begin
            count_in = '0;
            if (accept && (req_operation == OP_FILTER)) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            count_in = count_ff + CNT_BITS'(1);
            if (count_ff == LAST_TAP) begin
               count_in = '0;
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
            count_in = '0;
         end
      endcase
   end

   // Hold the result until the consumer takes it
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      rsp_clip_in  = rsp_clip_ff;
      if ((state_ff == ST_DONE) && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = mac_result;
         rsp_clip_in  = mac_clip;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_clip_ff <= rsp_clip_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Tap chain: cell 0 is the head that feeds the multiplier
   for (genvar k = 0; k < TAP_COUNT; k++) begin : g_cell
      fir_cb_cell #(
         .CELL_INDEX  (k),
         .SAMPLE_BITS (SAMPLE_BITS),
         .COEF_BITS   (COEF_BITS)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (cell_ctrl),
         .sample_prev ((k == 0) ? req_sample_in : sample_w[(k == 0) ? 0 : k - 1]),
         .sample_next (sample_w[(k + 1) % TAP_COUNT]),
         .coef_next   (coef_w[(k + 1) % TAP_COUNT]),
         .coef_load   (req_coef_value),
         .sample      (sample_w[k]),
         .coef        (coef_w[k])
      );
   end

   fir_cb_mac #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .COEF_BITS   (COEF_BITS)
   ) u_mac (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (mac_ctrl),
      .sample (sample_w[0]),
      .coef   (coef_w[0]),
      .result (mac_result),
      .clip   (mac_clip)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_filtered_out = rsp_data_ff;
   assign rsp_clipped      = rsp_clip_ff;

endmodule
